// ----- rtl/sha1bs_pkg.sv -----
// Package for the SHA-1 byte stream hasher: commands, queue word type,
// constants and round helper functions. No dependencies.
package sha1bs_pkg;

    typedef enum logic [1:0] {
        CMD_APPEND        = 2'd0,
        CMD_APPEND_FINISH = 2'd1,
        CMD_FINISH        = 2'd2,
        CMD_UNUSED        = 2'd3
    } cmd_t;

    // Word handed from front to back end
    typedef struct packed {
        logic       has_byte;
        logic       finish;
        logic [7:0] data;
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam int         LEN_POS  = 56;
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    function automatic logic [31:0] round_k(input logic [6:0] r);
        logic [31:0] k;
        begin
            if (r < 7'd20)
                k = 32'h5A827999;
            else if (r < 7'd40)
                k = 32'h6ED9EBA1;
            else if (r < 7'd60)
                k = 32'h8F1BBCDC;
            else
                k = 32'hCA62C1D6;
            return k;
        end
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        begin
            if (r < 7'd20)
                f = (b & c) | (~b & d);
            else if (r < 7'd40 || r >= 7'd60)
                f = b ^ c ^ d;
            else
                f = (b & c) | (b & d) | (c & d);
            return f;
        end
    endfunction

endpackage

// ----- rtl/sha1_byte_stream_hasher_unit.sv -----
// SHA-1 byte stream hasher, top level. Throughput: one byte per cycle into
// the back end while it is idle; each 64th byte starts a compression of 80
// rounds and a fold, during which no bytes are taken. Finish: padding one
// byte per cycle to the block end, one or two compressions, then five words,
// one per cycle while the receiver does not stall. Reset (async, rst_n low)
// loads the initial hash values, clears fill count, length and the queue. Uses sha1bs_pkg, _front, _back.
module sha1_byte_stream_hasher_unit
    import sha1bs_pkg::*;
#(
    parameter int LENGTH_COUNTER_BITS = 61
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    logic op_valid;
    logic op_take;
    op_t  op;

    sha1bs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (in_valid),
        .stall     (in_stall),
        .command   (command),
        .data_byte (data_byte),
        .op_valid  (op_valid),
        .op_take   (op_take),
        .op        (op)
    );

    sha1bs_back #(.LEN_BITS(LENGTH_COUNTER_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (op_valid),
        .op_take     (op_take),
        .op          (op),
        .valid       (out_valid),
        .stall       (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    // Last flag only on the fifth word
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd4)))
        else $error("last_word mismatch");

    // Word index advances after a taken word
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_word) |=> (out_valid &&
            word_index == $past(word_index) + 3'd1))
        else $error("word index skipped");

endmodule

// ----- rtl/sha1bs_front.sv -----
// Front end: accepts command words, drops unused codes, and queues
// the rest in a two-entry FIFO for the back end. Uses sha1bs_pkg.
module sha1bs_front
    import sha1bs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    output logic       stall,
    input  logic [1:0] command,
    input  logic [7:0] data_byte,
    output logic       op_valid,
    input  logic       op_take,
    output op_t        op
);

    op_t        q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;
    op_t        in_op;

    // Classify the incoming word
    always_comb
    begin
        in_op.has_byte = (command == CMD_APPEND) || (command == CMD_APPEND_FINISH);
        in_op.finish   = (command == CMD_APPEND_FINISH) || (command == CMD_FINISH);
        in_op.data     = data_byte;
    end

    assign stall    = (cnt_reg == 2'd2);
    assign push     = valid && !stall && (in_op.has_byte || in_op.finish);
    assign pop      = op_valid && op_take;
    assign op_valid = (cnt_reg != 2'd0);
    assign op       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= in_op;
    end

endmodule

// ----- rtl/sha1bs_back.sv -----
// Back end: 16-word schedule window that also holds the block bytes, one round
// per cycle compression, padding and digest output. Uses sha1bs_pkg.
module sha1bs_back
    import sha1bs_pkg::*;
#(
    parameter int LEN_BITS = 61
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        op_valid,
    output logic        op_take,
    input  op_t         op,
    output logic        valid,
    input  logic        stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    state_t state_reg, state_next;

    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] w_reg [16];
    logic [6:0]  rnd_reg;
    logic [5:0]  fill_reg;
    logic [LEN_BITS-1:0] len_reg;
    logic        fin_reg;      // padding in progress
    logic        lenblk_reg;   // current pad block holds the length
    logic        mark_reg;     // marker still to be written by the pad fill
    logic [2:0]  idx_reg;
    logic [31:0] wcur;
    logic [31:0] wxor;
    logic [31:0] wnew;
    logic [31:0] t;
    logic [63:0] bits;
    logic [7:0]  pad_byte;
    logic        fill_done;
    logic        mark_defer;
    logic [1:0]  adv;
    logic [6:0]  fill_sum;

    assign bits = 64'(len_reg) << 3;

    // Schedule word for this round
    assign wxor = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign wnew = {wxor[30:0], wxor[31]};
    assign wcur = (rnd_reg < 7'd16) ? w_reg[rnd_reg[3:0]] : wnew;
    assign t = {a_reg[26:0], a_reg[31:27]} + round_f(rnd_reg, b_reg, c_reg, d_reg)
             + e_reg + round_k(rnd_reg) + wcur;

    // Bytes stored by the taken word; a marker that would start the next
    // schedule word is left to the pad fill
    assign mark_defer = op.has_byte && op.finish && (fill_reg[1:0] == 2'd3);
    assign adv        = {1'b0, op.has_byte} + {1'b0, op.finish && !mark_defer};
    assign fill_sum   = {1'b0, fill_reg} + {5'b0, adv};

    // Padding byte at current fill position
    always_comb
    begin
        if (mark_reg)
            pad_byte = PAD_MARK;
        else if (lenblk_reg && fill_reg >= 6'(LEN_POS))
            pad_byte = bits[8*(7 - fill_reg[2:0]) +: 8];
        else
            pad_byte = 8'h00;
    end

    assign op_take   = (state_reg == ST_IDLE) && op_valid;
    assign fill_done = (fill_reg == 6'd63);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (op_valid)
                begin
                    if (fill_sum[6])
                        state_next = ST_ROUND;
                    else if (op.finish)
                        state_next = ST_PAD;
                end
            ST_PAD:
                if (fill_done)
                    state_next = ST_ROUND;
            ST_ROUND:
                if (rnd_reg == 7'd79)
                    state_next = ST_FOLD;
            ST_FOLD:
                if (!fin_reg)
                    state_next = ST_IDLE;
                else if (lenblk_reg)
                    state_next = ST_EMIT;
                else
                    state_next = ST_PAD;
            ST_EMIT:
                if (!stall && idx_reg == 3'd4)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        valid       = (state_reg == ST_EMIT);
        digest_word = h_reg[idx_reg];
        word_index  = idx_reg;
        last_word   = (idx_reg == 3'd4);
    end

    // Writes one byte into the schedule window
    function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] pos,
                                             input logic [7:0] v);
        logic [31:0] r;
        begin
            r = w;
            r[8*(3 - pos) +: 8] = v;
            return r;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            h_reg[0]   <= H0;
            h_reg[1]   <= H1;
            h_reg[2]   <= H2;
            h_reg[3]   <= H3;
            h_reg[4]   <= H4;
            fill_reg   <= 6'd0;
            len_reg    <= '0;
            fin_reg    <= 1'b0;
            lenblk_reg <= 1'b0;
            mark_reg   <= 1'b0;
            rnd_reg    <= 7'd0;
            idx_reg    <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                    if (op_valid)
                    begin
                        rnd_reg <= 7'd0;
                        if (op.has_byte)
                            len_reg <= len_reg + 1'b1;
                        fill_reg <= fill_sum[5:0];
                        fin_reg  <= op.finish;
                        mark_reg <= mark_defer;
                        if (op.finish)
                        begin
                            // Marker goes right after the data byte
                            lenblk_reg <= op.has_byte ? (fill_reg < 6'd55)
                                                      : (fill_reg < 6'd56);
                        end
                    end
                ST_PAD:
                begin
                    fill_reg <= fill_reg + 6'd1;
                    rnd_reg  <= 7'd0;
                    mark_reg <= 1'b0;
                end
                ST_ROUND:
                    rnd_reg <= rnd_reg + 7'd1;
                ST_FOLD:
                begin
                    if (fin_reg && lenblk_reg)
                        idx_reg <= 3'd0;
                    else if (fin_reg)
                        lenblk_reg <= 1'b1;
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                end
                ST_EMIT:
                    if (!stall)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd4)
                        begin
                            h_reg[0] <= H0;
                            h_reg[1] <= H1;
                            h_reg[2] <= H2;
                            h_reg[3] <= H3;
                            h_reg[4] <= H4;
                            fill_reg <= 6'd0;
                            len_reg  <= '0;
                            fin_reg  <= 1'b0;
                        end
                    end
                default:
                    ;
            endcase
        end
    end

    // Working variables and schedule window
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (op_valid)
                begin
                    // Byte and marker land in the same schedule word
                    if (op.has_byte && op.finish && !mark_defer)
                        w_reg[fill_reg[5:2]] <= put_byte(put_byte(w_reg[fill_reg[5:2]],
                                                                  fill_reg[1:0], op.data),
                                                         fill_reg[1:0] + 2'd1, PAD_MARK);
                    else if (op.has_byte)
                        w_reg[fill_reg[5:2]] <= put_byte(w_reg[fill_reg[5:2]],
                                                         fill_reg[1:0], op.data);
                    else
                        w_reg[fill_reg[5:2]] <= put_byte(w_reg[fill_reg[5:2]],
                                                         fill_reg[1:0], PAD_MARK);
                    a_reg <= h_reg[0];
                    b_reg <= h_reg[1];
                    c_reg <= h_reg[2];
                    d_reg <= h_reg[3];
                    e_reg <= h_reg[4];
                end
            ST_PAD:
            begin
                w_reg[fill_reg[5:2]] <= put_byte(w_reg[fill_reg[5:2]], fill_reg[1:0],
                                                 pad_byte);
                a_reg <= h_reg[0];
                b_reg <= h_reg[1];
                c_reg <= h_reg[2];
                d_reg <= h_reg[3];
                e_reg <= h_reg[4];
            end
            ST_ROUND:
            begin
                a_reg <= t;
                b_reg <= a_reg;
                c_reg <= {b_reg[1:0], b_reg[31:2]};
                d_reg <= c_reg;
                e_reg <= d_reg;
                if (rnd_reg >= 7'd16)
                begin
                    for (int i = 0; i < 15; i++)
                        w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= wnew;
                end
            end
            default:
                ;
        endcase
    end

endmodule

// ----- dv/sha1_stream_checker.sv -----
// Checker for the SHA-1 byte stream hasher: watches both word channels,
// predicts digests with its own SHA-1 model and compares. Uses sha1bs_pkg.
`timescale 1ns / 1ps

module sha1_stream_checker
    import sha1bs_pkg::*;
#(
    parameter int LENGTH_COUNTER_BITS = 61
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last_word,
    output int          fail_count,
    output int          digests_seen,
    output int          words_seen
);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_out_t;

    logic [31:0] chain [5];
    logic [7:0]  buffer [64];
    int          fill;
    logic [LENGTH_COUNTER_BITS-1:0] byte_count;
    digest_out_t expected_words [$];

    function automatic logic [31:0] rol(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // One SHA-1 compression of the block buffer into the chaining words
    task automatic compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {buffer[4*i], buffer[4*i+1], buffer[4*i+2], buffer[4*i+3]};
        for (int i = 16; i < 80; i++)
            w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endtask

    task automatic restart_message();
        chain[0] = H0; chain[1] = H1; chain[2] = H2; chain[3] = H3; chain[4] = H4;
        fill = 0;
        byte_count = '0;
    endtask

    task automatic absorb_byte(input logic [7:0] v);
        byte_count = byte_count + 1'b1;
        buffer[fill] = v;
        fill++;
        if (fill == 64)
        begin
            compress();
            fill = 0;
        end
    endtask

    // Pad, compress, queue the five digest words, restart
    task automatic close_message();
        logic [63:0] bits;
        digest_out_t dw;
        bits = 64'(byte_count) << 3;
        buffer[fill] = PAD_MARK;
        fill++;
        if (fill > LEN_POS)
        begin
            for (int i = fill; i < 64; i++)
                buffer[i] = 8'h00;
            compress();
            fill = 0;
        end
        for (int i = fill; i < LEN_POS; i++)
            buffer[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            buffer[LEN_POS+i] = bits[63-8*i -: 8];
        compress();
        for (int i = 0; i < 5; i++)
        begin
            dw.word  = chain[i];
            dw.index = 3'(i);
            dw.last  = (i == 4);
            expected_words.push_back(dw);
        end
        restart_message();
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        digests_seen = 0;
        words_seen = 0;
        restart_message();
    end

    // Sample both channels at the edge
    always @(posedge clk)
    begin
        digest_out_t exp_w;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                case (cmd_t'(command))
                    CMD_APPEND:        absorb_byte(data_byte);
                    CMD_APPEND_FINISH: begin absorb_byte(data_byte); close_message(); end
                    CMD_FINISH:        close_message();
                    default:           ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                words_seen++;
                if (expected_words.size() == 0)
                    report("unexpected word", digest_word, 32'h0);
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (digest_word !== exp_w.word)
                        report("digest_word", digest_word, exp_w.word);
                    if (word_index !== exp_w.index)
                        report("word_index", 32'(word_index), 32'(exp_w.index));
                    if (last_word !== exp_w.last)
                        report("last_word", 32'(last_word), 32'(exp_w.last));
                    if (exp_w.last)
                        digests_seen++;
                end
            end
        end
    end

    function automatic int pending();
        return expected_words.size();
    endfunction

endmodule

// ----- dv/tb_sha1_byte_stream_hasher_unit.sv -----
// Testbench top for the SHA-1 byte stream hasher: drives messages of
// random bytes with random idling and gives the verdict.
// Uses sha1bs_pkg, the hasher RTL and sha1_stream_checker.
`timescale 1ns / 1ps

module tb_sha1_byte_stream_hasher_unit;
    import sha1bs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = CMD_APPEND;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    int          fail_count, digests_seen, words_seen;
    int          items_sent = 0;
    int          idle_cycles = 0;
    bit          no_idle = 0;
    bit          hold_off = 0;

    always #6 clk = ~clk;

    sha1_byte_stream_hasher_unit dut (.*);

    sha1_stream_checker chk (.*);

    // Push one word through the input handshake
    task automatic send_word(input cmd_t cmd, input logic [7:0] b);
        while (!no_idle && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_message(input int len, input bit close_on_byte);
        for (int i = 0; i < len; i++)
            send_word((close_on_byte && i == len - 1) ? CMD_APPEND_FINISH : CMD_APPEND,
                      8'($urandom));
        if (!close_on_byte || len == 0)
            send_word(CMD_FINISH, 8'($urandom));
    endtask

    // Receiver stall: random, a no-idle stretch, and one long hold-off
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else if (no_idle)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 17);
    end

    // Watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[sha1_byte_stream_hasher_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        int len;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, single bytes, padding boundaries
        send_word(CMD_FINISH, 8'hFF);
        send_word(CMD_UNUSED, 8'h5A);
        send_word(CMD_APPEND_FINISH, 8'h00);
        send_word(CMD_APPEND_FINISH, 8'hFF);
        send_word(CMD_APPEND, 8'hAA);
        send_word(CMD_UNUSED, 8'h55);
        send_word(CMD_APPEND_FINISH, 8'h55);
        send_message(55, 1);
        send_message(56, 1);
        send_message(63, 0);
        send_message(64, 1);

        // Long hold-off on the output while input keeps coming
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            begin
                send_message(2, 1);
                send_message(1, 0);
                send_message(3, 1);
            end
        join

        // Stretch without idling on either side
        no_idle = 1;
        send_message(20, 1);
        send_message(0, 0);
        no_idle = 0;

        // Random messages: mostly short, a few long, sprinkled unused cmds
        while (items_sent < 330)
        begin
            if ($urandom_range(9) == 0)
                len = $urandom_range(120, 60);
            else
                len = $urandom_range(12);
            if (len > 330 - items_sent)
                len = 330 - items_sent;
            if ($urandom_range(9) == 0)
                send_word(CMD_UNUSED, 8'($urandom));
            send_message(len, $urandom_range(1));
        end
        in_valid <= 1'b0;

        while (chk.pending() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("sent %0d words, checked %0d digests (%0d words), incl. empty and",
                 items_sent, digests_seen, words_seen);
        $display("padding-overflow messages, unused commands and a long output hold-off");
        if (fail_count == 0)
            $display("[sha1_byte_stream_hasher_unit] OK");
        else
            $display("[sha1_byte_stream_hasher_unit] ERROR");
        $finish;
    end

endmodule
